/* hdl/assert_macros.svh */
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge while out of reset.
`define M65_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property at every clock edge, reset included.
`define M65_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/m65_pkg.sv */
// Types, codes and the opcode decode table of the 6502 subset core.
package m65_pkg;

  localparam int unsigned MAX_RES = 4;

  // action codes
  localparam logic [1:0] ACT_RESET = 2'd0;
  localparam logic [1:0] ACT_NMI   = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;
  localparam logic [1:0] ACT_DATA  = 2'd3;

  // request kinds
  localparam logic [1:0] K_READ  = 2'd0;
  localparam logic [1:0] K_WRITE = 2'd1;
  localparam logic [1:0] K_DONE  = 2'd2;
  localparam logic [1:0] K_UNIMP = 2'd3;

  // sequencer phases
  localparam logic [3:0] P_IDLE    = 4'd0;
  localparam logic [3:0] P_RST_LO  = 4'd1;
  localparam logic [3:0] P_RST_HI  = 4'd2;
  localparam logic [3:0] P_NMI_LO  = 4'd3;
  localparam logic [3:0] P_NMI_HI  = 4'd4;
  localparam logic [3:0] P_FETCH   = 4'd5;
  localparam logic [3:0] P_OP1     = 4'd6;
  localparam logic [3:0] P_OP2     = 4'd7;
  localparam logic [3:0] P_PTR_LO  = 4'd8;
  localparam logic [3:0] P_PTR_HI  = 4'd9;
  localparam logic [3:0] P_OPERAND = 4'd10;
  localparam logic [3:0] P_POP_A   = 4'd11;
  localparam logic [3:0] P_POP_B   = 4'd12;
  localparam logic [3:0] P_POP_C   = 4'd13;

  // flag bit positions
  localparam int unsigned FB_C = 0;
  localparam int unsigned FB_Z = 1;
  localparam int unsigned FB_I = 2;
  localparam int unsigned FB_D = 3;
  localparam int unsigned FB_B = 4;
  localparam int unsigned FB_U = 5;
  localparam int unsigned FB_V = 6;
  localparam int unsigned FB_N = 7;

  localparam logic [7:0]  SP_RESET  = 8'hFD;
  localparam logic [7:0]  P_RESET   = 8'b0010_0000;
  localparam logic [15:0] VEC_RESET = 16'hFFFC;
  localparam logic [15:0] VEC_NMI   = 16'hFFFA;
  localparam logic [7:0]  STACK_PAGE = 8'h01;

  // addressing modes
  localparam logic [3:0] M_IMP = 4'd0;
  localparam logic [3:0] M_IMM = 4'd1;
  localparam logic [3:0] M_ZP  = 4'd2;
  localparam logic [3:0] M_ZPX = 4'd3;
  localparam logic [3:0] M_ZPY = 4'd4;
  localparam logic [3:0] M_ABS = 4'd5;
  localparam logic [3:0] M_ABX = 4'd6;
  localparam logic [3:0] M_ABY = 4'd7;
  localparam logic [3:0] M_IZX = 4'd8;
  localparam logic [3:0] M_IZY = 4'd9;
  localparam logic [3:0] M_REL = 4'd10;
  localparam logic [3:0] M_IND = 4'd11;

  // operations
  localparam logic [5:0] O_LDA = 6'd0,  O_STA = 6'd1,  O_LDX = 6'd2,  O_STX = 6'd3;
  localparam logic [5:0] O_LDY = 6'd4,  O_STY = 6'd5,  O_TAX = 6'd6,  O_TXA = 6'd7;
  localparam logic [5:0] O_TAY = 6'd8,  O_TYA = 6'd9,  O_ADC = 6'd10, O_SBC = 6'd11;
  localparam logic [5:0] O_INC = 6'd12, O_DEC = 6'd13, O_INX = 6'd14, O_DEX = 6'd15;
  localparam logic [5:0] O_INY = 6'd16, O_DEY = 6'd17, O_AND = 6'd18, O_ORA = 6'd19;
  localparam logic [5:0] O_EOR = 6'd20, O_BIT = 6'd21, O_CMP = 6'd22, O_CPX = 6'd23;
  localparam logic [5:0] O_CPY = 6'd24, O_BRA = 6'd25, O_JMP = 6'd26, O_JSR = 6'd27;
  localparam logic [5:0] O_RTS = 6'd28, O_RTI = 6'd29, O_PHA = 6'd30, O_PHP = 6'd31;
  localparam logic [5:0] O_PLA = 6'd32, O_PLP = 6'd33, O_TXS = 6'd34, O_TSX = 6'd35;
  localparam logic [5:0] O_SEI = 6'd36, O_CLD = 6'd37, O_NOP = 6'd38;

  typedef struct packed {
    logic       ok;
    logic [5:0] op;
    logic [3:0] mode;
    logic [2:0] cyc;
  } m65_dec_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [2:0]  cyc;
  } m65_res_t;

  typedef m65_res_t [MAX_RES-1:0] m65_res_arr_t;

  typedef struct packed {
    logic [7:0]  a;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  sp;
    logic [7:0]  p;
    logic [15:0] pc;
    logic        nmi;
    logic [7:0]  op;
    logic [15:0] ea;
    logic [7:0]  tmp;
    logic [3:0]  phase;
    logic [2:0]  extra;
  } m65_state_t;

  function automatic m65_dec_t dk(logic [5:0] op, logic [3:0] mode, logic [2:0] cyc);
    dk = '{ok: 1'b1, op: op, mode: mode, cyc: cyc};
  endfunction

  // Opcode decode table; unlisted codes come back with ok clear.
  function automatic m65_dec_t decode(logic [7:0] code);
    m65_dec_t e;
    e = '0;
    unique case (code)
      8'hA9: e = dk(O_LDA, M_IMM, 3'd2);  8'hA5: e = dk(O_LDA, M_ZP, 3'd3);
      8'hB5: e = dk(O_LDA, M_ZPX, 3'd4);  8'hAD: e = dk(O_LDA, M_ABS, 3'd4);
      8'hBD: e = dk(O_LDA, M_ABX, 3'd4);  8'hB9: e = dk(O_LDA, M_ABY, 3'd4);
      8'hA1: e = dk(O_LDA, M_IZX, 3'd6);  8'hB1: e = dk(O_LDA, M_IZY, 3'd5);
      8'h85: e = dk(O_STA, M_ZP, 3'd3);   8'h95: e = dk(O_STA, M_ZPX, 3'd4);
      8'h8D: e = dk(O_STA, M_ABS, 3'd4);  8'h9D: e = dk(O_STA, M_ABX, 3'd5);
      8'h99: e = dk(O_STA, M_ABY, 3'd5);  8'h81: e = dk(O_STA, M_IZX, 3'd6);
      8'h91: e = dk(O_STA, M_IZY, 3'd6);
      8'hA2: e = dk(O_LDX, M_IMM, 3'd2);  8'hA6: e = dk(O_LDX, M_ZP, 3'd3);
      8'hB6: e = dk(O_LDX, M_ZPY, 3'd4);  8'hAE: e = dk(O_LDX, M_ABS, 3'd4);
      8'hBE: e = dk(O_LDX, M_ABY, 3'd4);  8'h86: e = dk(O_STX, M_ZP, 3'd3);
      8'h96: e = dk(O_STX, M_ZPY, 3'd4);  8'h8E: e = dk(O_STX, M_ABS, 3'd4);
      8'hA0: e = dk(O_LDY, M_IMM, 3'd2);  8'hA4: e = dk(O_LDY, M_ZP, 3'd3);
      8'hB4: e = dk(O_LDY, M_ZPX, 3'd4);  8'hAC: e = dk(O_LDY, M_ABS, 3'd4);
      8'hBC: e = dk(O_LDY, M_ABX, 3'd4);  8'h84: e = dk(O_STY, M_ZP, 3'd3);
      8'h94: e = dk(O_STY, M_ZPX, 3'd4);  8'h8C: e = dk(O_STY, M_ABS, 3'd4);
      8'hAA: e = dk(O_TAX, M_IMP, 3'd2);  8'h8A: e = dk(O_TXA, M_IMP, 3'd2);
      8'hA8: e = dk(O_TAY, M_IMP, 3'd2);  8'h98: e = dk(O_TYA, M_IMP, 3'd2);
      8'h69: e = dk(O_ADC, M_IMM, 3'd2);  8'h65: e = dk(O_ADC, M_ZP, 3'd3);
      8'h75: e = dk(O_ADC, M_ZPX, 3'd4);  8'h6D: e = dk(O_ADC, M_ABS, 3'd4);
      8'h7D: e = dk(O_ADC, M_ABX, 3'd4);  8'h79: e = dk(O_ADC, M_ABY, 3'd4);
      8'h61: e = dk(O_ADC, M_IZX, 3'd6);  8'h71: e = dk(O_ADC, M_IZY, 3'd5);
      8'hE9: e = dk(O_SBC, M_IMM, 3'd2);  8'hE5: e = dk(O_SBC, M_ZP, 3'd3);
      8'hF5: e = dk(O_SBC, M_ZPX, 3'd4);  8'hED: e = dk(O_SBC, M_ABS, 3'd4);
      8'hFD: e = dk(O_SBC, M_ABX, 3'd4);  8'hF9: e = dk(O_SBC, M_ABY, 3'd4);
      8'hE1: e = dk(O_SBC, M_IZX, 3'd6);  8'hF1: e = dk(O_SBC, M_IZY, 3'd5);
      8'hE6: e = dk(O_INC, M_ZP, 3'd5);   8'hF6: e = dk(O_INC, M_ZPX, 3'd6);
      8'hEE: e = dk(O_INC, M_ABS, 3'd6);  8'hFE: e = dk(O_INC, M_ABX, 3'd7);
      8'hC6: e = dk(O_DEC, M_ZP, 3'd5);   8'hD6: e = dk(O_DEC, M_ZPX, 3'd6);
      8'hCE: e = dk(O_DEC, M_ABS, 3'd6);  8'hDE: e = dk(O_DEC, M_ABX, 3'd7);
      8'hE8: e = dk(O_INX, M_IMP, 3'd2);  8'hCA: e = dk(O_DEX, M_IMP, 3'd2);
      8'hC8: e = dk(O_INY, M_IMP, 3'd2);  8'h88: e = dk(O_DEY, M_IMP, 3'd2);
      8'h29: e = dk(O_AND, M_IMM, 3'd2);  8'h25: e = dk(O_AND, M_ZP, 3'd3);
      8'h35: e = dk(O_AND, M_ZPX, 3'd4);  8'h2D: e = dk(O_AND, M_ABS, 3'd4);
      8'h3D: e = dk(O_AND, M_ABX, 3'd4);  8'h39: e = dk(O_AND, M_ABY, 3'd4);
      8'h21: e = dk(O_AND, M_IZX, 3'd6);  8'h31: e = dk(O_AND, M_IZY, 3'd5);
      8'h09: e = dk(O_ORA, M_IMM, 3'd2);  8'h05: e = dk(O_ORA, M_ZP, 3'd3);
      8'h15: e = dk(O_ORA, M_ZPX, 3'd4);  8'h0D: e = dk(O_ORA, M_ABS, 3'd4);
      8'h1D: e = dk(O_ORA, M_ABX, 3'd4);  8'h19: e = dk(O_ORA, M_ABY, 3'd4);
      8'h01: e = dk(O_ORA, M_IZX, 3'd6);  8'h11: e = dk(O_ORA, M_IZY, 3'd5);
      8'h49: e = dk(O_EOR, M_IMM, 3'd2);  8'h45: e = dk(O_EOR, M_ZP, 3'd3);
      8'h55: e = dk(O_EOR, M_ZPX, 3'd4);  8'h4D: e = dk(O_EOR, M_ABS, 3'd4);
      8'h5D: e = dk(O_EOR, M_ABX, 3'd4);  8'h59: e = dk(O_EOR, M_ABY, 3'd4);
      8'h41: e = dk(O_EOR, M_IZX, 3'd6);  8'h51: e = dk(O_EOR, M_IZY, 3'd5);
      8'h24: e = dk(O_BIT, M_ZP, 3'd3);   8'h2C: e = dk(O_BIT, M_ABS, 3'd4);
      8'hC9: e = dk(O_CMP, M_IMM, 3'd2);  8'hC5: e = dk(O_CMP, M_ZP, 3'd3);
      8'hD5: e = dk(O_CMP, M_ZPX, 3'd4);  8'hCD: e = dk(O_CMP, M_ABS, 3'd4);
      8'hDD: e = dk(O_CMP, M_ABX, 3'd4);  8'hD9: e = dk(O_CMP, M_ABY, 3'd4);
      8'hC1: e = dk(O_CMP, M_IZX, 3'd6);  8'hD1: e = dk(O_CMP, M_IZY, 3'd5);
      8'hE0: e = dk(O_CPX, M_IMM, 3'd2);  8'hE4: e = dk(O_CPX, M_ZP, 3'd3);
      8'hEC: e = dk(O_CPX, M_ABS, 3'd4);
      8'hC0: e = dk(O_CPY, M_IMM, 3'd2);  8'hC4: e = dk(O_CPY, M_ZP, 3'd3);
      8'hCC: e = dk(O_CPY, M_ABS, 3'd4);
      8'h90, 8'hB0, 8'hF0, 8'hD0,
      8'h10, 8'h30, 8'h50, 8'h70: e = dk(O_BRA, M_REL, 3'd2);
      8'h4C: e = dk(O_JMP, M_ABS, 3'd3);  8'h6C: e = dk(O_JMP, M_IND, 3'd5);
      8'h20: e = dk(O_JSR, M_ABS, 3'd6);  8'h60: e = dk(O_RTS, M_IMP, 3'd6);
      8'h40: e = dk(O_RTI, M_IMP, 3'd6);  8'h48: e = dk(O_PHA, M_IMP, 3'd3);
      8'h08: e = dk(O_PHP, M_IMP, 3'd3);  8'h68: e = dk(O_PLA, M_IMP, 3'd4);
      8'h28: e = dk(O_PLP, M_IMP, 3'd4);  8'h9A: e = dk(O_TXS, M_IMP, 3'd2);
      8'hBA: e = dk(O_TSX, M_IMP, 3'd2);  8'h78: e = dk(O_SEI, M_IMP, 3'd2);
      8'hD8: e = dk(O_CLD, M_IMP, 3'd2);  8'hEA: e = dk(O_NOP, M_IMP, 3'd2);
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

/* hdl/m65_if.sv */
// Valid/ready channel interfaces for the input and result words.
interface m65_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] read_data;

  modport source (output valid, output action, output read_data, input ready);
  modport sink (input valid, input action, input read_data, output ready);
endinterface

interface m65_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  request_kind;
  logic [15:0] bus_address;
  logic [7:0]  write_data;
  logic [2:0]  cycle_count;

  modport source (output valid, output request_kind, output bus_address,
                  output write_data, output cycle_count, input ready);
  modport sink (input valid, input request_kind, input bus_address,
                input write_data, input cycle_count, output ready);
endinterface

/* hdl/m65_exec.sv */
// One bus event of the core: next architectural state and up to four result words.
module m65_exec
  import m65_pkg::*;
(
  input  m65_state_t   st_i,
  input  logic [1:0]   action_i,
  input  logic [7:0]   rdata_i,
  output m65_state_t   st_o,
  output m65_res_arr_t res_o,
  output logic [2:0]   cnt_o
);

  m65_state_t   s;
  m65_res_arr_t res;
  logic [2:0]   n;
  m65_dec_t     e;
  logic         addr_rdy;
  logic         do_fin;
  logic [15:0]  base;
  logic [15:0]  ret;
  logic [8:0]   sum;
  logic [7:0]   m;
  logic [7:0]   v;
  logic         flg;
  logic         reads;

  always_comb begin
    s        = st_i;
    res      = '0;
    n        = 3'd0;
    addr_rdy = 1'b0;
    do_fin   = 1'b0;
    base     = '0;
    ret      = '0;
    sum      = '0;
    m        = '0;
    v        = '0;
    flg      = 1'b0;
    e        = decode((st_i.phase == P_FETCH) ? rdata_i : st_i.op);
    reads    = (e.op != O_STA) && (e.op != O_INC) && (e.op != O_DEC);

    unique case (action_i)
      ACT_RESET: begin
        s.a = '0; s.x = '0; s.y = '0;
        s.sp = SP_RESET; s.p = P_RESET; s.extra = '0;
        s.phase = P_RST_LO;
        res[n[1:0]] = '{K_READ, VEC_RESET, 8'h00, 3'd0}; n = n + 3'd1;
      end
      ACT_NMI: begin
        s.nmi = 1'b1;
      end
      ACT_START: begin
        if (s.phase == P_IDLE) begin
          if (s.nmi) begin
            // push return address and flags, then fetch the vector
            res[n[1:0]] = '{K_WRITE, {STACK_PAGE, s.sp}, s.pc[15:8], 3'd0};
            n = n + 3'd1; s.sp = s.sp - 8'd1;
            res[n[1:0]] = '{K_WRITE, {STACK_PAGE, s.sp}, s.pc[7:0], 3'd0};
            n = n + 3'd1; s.sp = s.sp - 8'd1;
            v = s.p; v[FB_B] = 1'b0; v[FB_U] = 1'b1;
            res[n[1:0]] = '{K_WRITE, {STACK_PAGE, s.sp}, v, 3'd0};
            n = n + 3'd1; s.sp = s.sp - 8'd1;
            s.p[FB_I] = 1'b1;
            s.phase = P_NMI_LO;
            res[n[1:0]] = '{K_READ, VEC_NMI, 8'h00, 3'd0}; n = n + 3'd1;
          end else begin
            s.phase = P_FETCH;
            res[n[1:0]] = '{K_READ, s.pc, 8'h00, 3'd0}; n = n + 3'd1;
            s.pc = s.pc + 16'd1;
          end
        end
      end
      default: begin
        if (s.phase != P_IDLE) begin
          unique case (s.phase)
            P_RST_LO, P_NMI_LO: begin
              s.tmp = rdata_i;
              res[n[1:0]] = '{K_READ, (s.phase == P_RST_LO) ? 16'hFFFD : 16'hFFFB,
                              8'h00, 3'd0};
              n = n + 3'd1;
              s.phase = s.phase + 4'd1;
            end
            P_RST_HI, P_NMI_HI: begin
              s.pc = {rdata_i, s.tmp};
              if (s.phase == P_NMI_HI) begin
                s.nmi = 1'b0;
                res[n[1:0]] = '{K_DONE, s.pc, 8'h00, 3'd7};
              end else begin
                res[n[1:0]] = '{K_DONE, s.pc, 8'h00, 3'd0};
              end
              n = n + 3'd1;
              s.phase = P_IDLE;
            end
            P_FETCH: begin
              s.op = rdata_i;
              if (!e.ok) begin
                // rewind onto the rejected opcode
                s.pc = s.pc - 16'd1;
                s.phase = P_IDLE;
                res[n[1:0]] = '{K_UNIMP, s.pc, rdata_i, 3'd0}; n = n + 3'd1;
              end else begin
                s.extra = '0;
                if (e.mode == M_IMP) begin
                  do_fin = 1'b1;
                  case (e.op)
                    O_TAX: begin s.x = s.a; s.p[FB_N] = s.x[7]; s.p[FB_Z] = (s.x == 0); end
                    O_TXA: begin s.a = s.x; s.p[FB_N] = s.a[7]; s.p[FB_Z] = (s.a == 0); end
                    O_TAY: begin s.y = s.a; s.p[FB_N] = s.y[7]; s.p[FB_Z] = (s.y == 0); end
                    O_TYA: begin s.a = s.y; s.p[FB_N] = s.a[7]; s.p[FB_Z] = (s.a == 0); end
                    O_INX: begin
                      s.x = s.x + 8'd1; s.p[FB_N] = s.x[7]; s.p[FB_Z] = (s.x == 0);
                    end
                    O_DEX: begin
                      s.x = s.x - 8'd1; s.p[FB_N] = s.x[7]; s.p[FB_Z] = (s.x == 0);
                    end
                    O_INY: begin
                      s.y = s.y + 8'd1; s.p[FB_N] = s.y[7]; s.p[FB_Z] = (s.y == 0);
                    end
                    O_DEY: begin
                      s.y = s.y - 8'd1; s.p[FB_N] = s.y[7]; s.p[FB_Z] = (s.y == 0);
                    end
                    O_TXS: s.sp = s.x;
                    O_TSX: begin s.x = s.sp; s.p[FB_N] = s.x[7]; s.p[FB_Z] = (s.x == 0); end
                    O_SEI: s.p[FB_I] = 1'b1;
                    O_CLD: s.p[FB_D] = 1'b0;
                    O_PHA: begin
                      res[n[1:0]] = '{K_WRITE, {STACK_PAGE, s.sp}, s.a, 3'd0};
                      n = n + 3'd1; s.sp = s.sp - 8'd1;
                    end
                    O_PHP: begin
                      v = s.p; v[FB_B] = 1'b1; v[FB_U] = 1'b1;
                      res[n[1:0]] = '{K_WRITE, {STACK_PAGE, s.sp}, v, 3'd0};
                      n = n + 3'd1; s.sp = s.sp - 8'd1;
                    end
                    O_PLA, O_PLP, O_RTS, O_RTI: begin
                      do_fin = 1'b0;
                      s.sp = s.sp + 8'd1;
                      s.phase = P_POP_A;
                      res[n[1:0]] = '{K_READ, {STACK_PAGE, s.sp}, 8'h00, 3'd0};
                      n = n + 3'd1;
                    end
                    default: ;
                  endcase
                end else if (e.mode == M_IMM) begin
                  s.ea = s.pc;
                  s.pc = s.pc + 16'd1;
                  addr_rdy = 1'b1;
                end else begin
                  s.phase = P_OP1;
                  res[n[1:0]] = '{K_READ, s.pc, 8'h00, 3'd0}; n = n + 3'd1;
                  s.pc = s.pc + 16'd1;
                end
              end
            end
            default: begin
              if (!e.ok) begin
                s.phase = P_IDLE;
              end else begin
                unique case (s.phase)
                  P_OP1: begin
                    case (e.mode)
                      M_ZP: begin s.ea = {8'h00, rdata_i}; addr_rdy = 1'b1; end
                      M_ZPX: begin s.ea = {8'h00, rdata_i + s.x}; addr_rdy = 1'b1; end
                      M_ZPY: begin s.ea = {8'h00, rdata_i + s.y}; addr_rdy = 1'b1; end
                      M_IZX, M_IZY: begin
                        s.ea = {8'h00, (e.mode == M_IZX) ? rdata_i + s.x : rdata_i};
                        s.phase = P_PTR_LO;
                        res[n[1:0]] = '{K_READ, s.ea, 8'h00, 3'd0}; n = n + 3'd1;
                      end
                      M_REL: begin
                        s.ea = s.pc + {{8{rdata_i[7]}}, rdata_i};
                        case (s.op[7:6])
                          2'd0: flg = s.p[FB_N];
                          2'd1: flg = s.p[FB_V];
                          2'd2: flg = s.p[FB_C];
                          default: flg = s.p[FB_Z];
                        endcase
                        if (flg == s.op[5]) begin
                          s.extra = (s.pc[15:8] != s.ea[15:8]) ? 3'd2 : 3'd1;
                          s.pc = s.ea;
                        end
                        do_fin = 1'b1;
                      end
                      default: begin
                        s.tmp = rdata_i;
                        s.phase = P_OP2;
                        res[n[1:0]] = '{K_READ, s.pc, 8'h00, 3'd0}; n = n + 3'd1;
                        s.pc = s.pc + 16'd1;
                      end
                    endcase
                  end
                  P_OP2: begin
                    base = {rdata_i, s.tmp};
                    s.ea = base;
                    if (e.mode == M_IND) begin
                      s.phase = P_PTR_LO;
                      res[n[1:0]] = '{K_READ, s.ea, 8'h00, 3'd0}; n = n + 3'd1;
                    end else begin
                      if (e.mode == M_ABX) s.ea = base + {8'h00, s.x};
                      if (e.mode == M_ABY) s.ea = base + {8'h00, s.y};
                      s.extra = {2'b00, (base[15:8] != s.ea[15:8]) && reads};
                      addr_rdy = 1'b1;
                    end
                  end
                  P_PTR_LO: begin
                    // high pointer byte wraps within the page
                    s.tmp = rdata_i;
                    s.phase = P_PTR_HI;
                    res[n[1:0]] = '{K_READ, {s.ea[15:8], s.ea[7:0] + 8'd1}, 8'h00, 3'd0};
                    n = n + 3'd1;
                  end
                  P_PTR_HI: begin
                    base = {rdata_i, s.tmp};
                    s.ea = base;
                    if (e.mode == M_IZY) begin
                      s.ea = base + {8'h00, s.y};
                      s.extra = {2'b00, (base[15:8] != s.ea[15:8]) && reads};
                    end
                    addr_rdy = 1'b1;
                  end
                  P_OPERAND: begin
                    do_fin = 1'b1;
                    case (e.op)
                      O_LDA: begin
                        s.a = rdata_i; s.p[FB_N] = s.a[7]; s.p[FB_Z] = (s.a == 0);
                      end
                      O_LDX: begin
                        s.x = rdata_i; s.p[FB_N] = s.x[7]; s.p[FB_Z] = (s.x == 0);
                      end
                      O_LDY: begin
                        s.y = rdata_i; s.p[FB_N] = s.y[7]; s.p[FB_Z] = (s.y == 0);
                      end
                      O_ADC, O_SBC: begin
                        m = (e.op == O_SBC) ? ~rdata_i : rdata_i;
                        sum = {1'b0, s.a} + {1'b0, m} + {8'h00, s.p[FB_C]};
                        s.p[FB_C] = sum[8];
                        s.p[FB_V] = (sum[7] ^ s.a[7]) & (sum[7] ^ m[7]);
                        s.a = sum[7:0];
                        s.p[FB_N] = s.a[7]; s.p[FB_Z] = (s.a == 0);
                      end
                      O_INC, O_DEC: begin
                        v = (e.op == O_INC) ? rdata_i + 8'd1 : rdata_i - 8'd1;
                        res[n[1:0]] = '{K_WRITE, s.ea, rdata_i, 3'd0}; n = n + 3'd1;
                        res[n[1:0]] = '{K_WRITE, s.ea, v, 3'd0}; n = n + 3'd1;
                        s.p[FB_N] = v[7]; s.p[FB_Z] = (v == 0);
                      end
                      O_AND: begin
                        s.a = s.a & rdata_i; s.p[FB_N] = s.a[7]; s.p[FB_Z] = (s.a == 0);
                      end
                      O_ORA: begin
                        s.a = s.a | rdata_i; s.p[FB_N] = s.a[7]; s.p[FB_Z] = (s.a == 0);
                      end
                      O_EOR: begin
                        s.a = s.a ^ rdata_i; s.p[FB_N] = s.a[7]; s.p[FB_Z] = (s.a == 0);
                      end
                      O_BIT: begin
                        s.p[FB_Z] = ((s.a & rdata_i) == 0);
                        s.p[FB_V] = rdata_i[6];
                        s.p[FB_N] = rdata_i[7];
                      end
                      O_CMP, O_CPX, O_CPY: begin
                        m = (e.op == O_CMP) ? s.a : ((e.op == O_CPX) ? s.x : s.y);
                        v = m - rdata_i;
                        s.p[FB_C] = (m >= rdata_i);
                        s.p[FB_Z] = (m == rdata_i);
                        s.p[FB_N] = v[7];
                      end
                      default: ;
                    endcase
                  end
                  P_POP_A: begin
                    case (e.op)
                      O_PLA: begin
                        s.a = rdata_i; s.p[FB_N] = s.a[7]; s.p[FB_Z] = (s.a == 0);
                        do_fin = 1'b1;
                      end
                      O_PLP: begin s.p = rdata_i; do_fin = 1'b1; end
                      default: begin
                        if (e.op == O_RTI) s.p = rdata_i;
                        else s.tmp = rdata_i;
                        s.sp = s.sp + 8'd1;
                        s.phase = P_POP_B;
                        res[n[1:0]] = '{K_READ, {STACK_PAGE, s.sp}, 8'h00, 3'd0};
                        n = n + 3'd1;
                      end
                    endcase
                  end
                  P_POP_B, P_POP_C: begin
                    if (s.phase == P_POP_B && e.op == O_RTI) begin
                      s.tmp = rdata_i;
                      s.sp = s.sp + 8'd1;
                      s.phase = P_POP_C;
                      res[n[1:0]] = '{K_READ, {STACK_PAGE, s.sp}, 8'h00, 3'd0};
                      n = n + 3'd1;
                    end else begin
                      s.pc = {rdata_i, s.tmp};
                      if (e.op == O_RTS) s.pc = s.pc + 16'd1;
                      do_fin = 1'b1;
                    end
                  end
                  default: s.phase = P_IDLE;
                endcase
              end
            end
          endcase
        end
      end
    endcase

    // effective address known: store, jump or operand read
    if (addr_rdy) begin
      case (e.op)
        O_STA: begin
          res[n[1:0]] = '{K_WRITE, s.ea, s.a, 3'd0}; n = n + 3'd1; do_fin = 1'b1;
        end
        O_STX: begin
          res[n[1:0]] = '{K_WRITE, s.ea, s.x, 3'd0}; n = n + 3'd1; do_fin = 1'b1;
        end
        O_STY: begin
          res[n[1:0]] = '{K_WRITE, s.ea, s.y, 3'd0}; n = n + 3'd1; do_fin = 1'b1;
        end
        O_JMP: begin s.pc = s.ea; do_fin = 1'b1; end
        O_JSR: begin
          ret = s.pc - 16'd1;
          res[n[1:0]] = '{K_WRITE, {STACK_PAGE, s.sp}, ret[15:8], 3'd0};
          n = n + 3'd1; s.sp = s.sp - 8'd1;
          res[n[1:0]] = '{K_WRITE, {STACK_PAGE, s.sp}, ret[7:0], 3'd0};
          n = n + 3'd1; s.sp = s.sp - 8'd1;
          s.pc = s.ea;
          do_fin = 1'b1;
        end
        default: begin
          s.phase = P_OPERAND;
          res[n[1:0]] = '{K_READ, s.ea, 8'h00, 3'd0}; n = n + 3'd1;
        end
      endcase
    end

    // report the finished instruction
    if (do_fin) begin
      s.phase = P_IDLE;
      res[n[1:0]] = '{K_DONE, s.pc, 8'h00, e.cyc + s.extra}; n = n + 3'd1;
    end

    st_o  = s;
    res_o = res;
    cnt_o = n;
  end

endmodule

/* hdl/mos6502_subset_core.sv */
// Top level of the 6502 subset core: state registers and result word buffer.
//
// Usage: the host sends one word per bus event on in_ch (action, read_data):
// reset, raise NMI, start next instruction, or the byte answering the last
// read request. Each accepted word yields zero to four result words on
// out_ch: bus reads and writes, an instruction-done report with its cycle
// count, or an unimplemented-opcode report. The core only issues a request;
// memory lives outside and answers reads through a later data word.
// An accepted word updates the registers, and its first result word is shown
// on out_ch in the next cycle.
// Throughput: one input word per cycle while each word yields at most one
// result and out_ch is ready; a word with more results holds the input until
// the single result port has drained the four-entry result buffer.
// Reset (rst_n low) clears the registers to the power-on values and empties
// the buffer; the program counter is loaded by a reset action word.
// When out_ch stalls, the buffered words hold and in_ch ready drops once
// the last buffered word is not being taken.
module mos6502_subset_core
  import m65_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  m65_in_if.sink       in_ch,
  m65_out_if.source    out_ch
);

`include "assert_macros.svh"

  m65_state_t   st_r, st_nxt;
  m65_res_arr_t res_r, res_nxt;
  logic [2:0]   cnt_r, cnt_nxt;
  logic [2:0]   head_r;
  logic         in_fire, out_fire, last_word;

  m65_exec u_exec (
    .st_i     (st_r),
    .action_i (in_ch.action),
    .rdata_i  (in_ch.read_data),
    .st_o     (st_nxt),
    .res_o    (res_nxt),
    .cnt_o    (cnt_nxt)
  );

  // drive result channel from buffer head
  assign out_ch.valid        = (head_r < cnt_r);
  assign out_ch.request_kind = res_r[head_r[1:0]].kind;
  assign out_ch.bus_address  = res_r[head_r[1:0]].addr;
  assign out_ch.write_data   = res_r[head_r[1:0]].data;
  assign out_ch.cycle_count  = res_r[head_r[1:0]].cyc;

  assign out_fire  = out_ch.valid && out_ch.ready;
  assign last_word = (head_r + 3'd1 == cnt_r);
  assign in_ch.ready = !out_ch.valid || (out_ch.ready && last_word);
  assign in_fire   = in_ch.valid && in_ch.ready;

  // advance state and buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= '{a: 8'h00, x: 8'h00, y: 8'h00, sp: SP_RESET, p: P_RESET,
                  pc: 16'h0000, nmi: 1'b0, op: 8'h00, ea: 16'h0000, tmp: 8'h00,
                  phase: P_IDLE, extra: 3'd0};
      cnt_r  <= '0;
      head_r <= '0;
    end else if (in_fire) begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      head_r <= '0;
    end else if (out_fire) begin
      head_r <= head_r + 3'd1;
    end
  end

  // buffer payload needs no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  `M65_ASSERT(a_head_le_cnt, head_r <= cnt_r, "buffer head ran past count")
  `M65_ASSERT(a_cnt_max, cnt_r <= 3'd4, "more than four result words buffered")
  `M65_ASSERT(a_fire_restart, in_fire |=> (head_r == 3'd0), "buffer not restarted")
  `M65_ASSERT(a_no_drop, (out_ch.valid && !out_ch.ready && !last_word) |-> !in_ch.ready,
              "input taken while results pending")

endmodule
